@@ src/rcug_pkg.sv @@
// Shared types and constants for the raised-cosine upslew gate.
package rcug_pkg;

  localparam int CMD_W       = 2;
  localparam int RAMP_IDX_W  = 10;
  localparam int DELAY_W     = 16;
  localparam int RAMP_LEN_W  = 10;
  localparam int CNT_W       = 16;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 16;
  localparam int OP_KIND_W   = 2;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [CFG_IDX_W-1:0] REG_DELAY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP  = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_SAMPLE  = 2'd0,
    CMD_FLUSH   = 2'd1,
    CMD_SET_RUN = 2'd2,
    CMD_LOAD    = 2'd3
  } cmd_e;

  typedef enum logic [OP_KIND_W-1:0] {
    OP_PASS = 2'd0,
    OP_ZERO = 2'd1,
    OP_RAMP = 2'd2,
    OP_LOAD = 2'd3
  } op_kind_e;

  typedef enum logic [3:0] {
    PH_BEGIN = 4'b0001,
    PH_WAIT  = 4'b0010,
    PH_UP    = 4'b0100,
    PH_ON    = 4'b1000
  } phase_e;

endpackage

@@ src/rcug_front.sv @@
// Front end: accepts words, runs the gating state machine, emits work ops.
module rcug_front #(
  parameter int SW         = 16,
  parameter int GW         = 17,
  parameter int AW         = 10,
  parameter int RAMP_DEPTH = 1024,
  localparam int OP_W      = rcug_pkg::OP_KIND_W + AW + GW + 2 * SW
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [rcug_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [rcug_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [rcug_pkg::CMD_W-1:0]        command_i,
  input  logic                              block_start_i,
  input  logic                              check_i,
  input  logic                              run_value_i,
  input  logic signed [SW-1:0]              i_in_i,
  input  logic signed [SW-1:0]              q_in_i,
  input  logic [rcug_pkg::RAMP_IDX_W-1:0]   ramp_index_i,
  input  logic [GW-1:0]                     ramp_gain_i,
  output logic                              push_valid_o,
  input  logic                              push_ready_i,
  output logic [OP_W-1:0]                   push_op_o
);
  import rcug_pkg::*;

  typedef struct packed {
    op_kind_e             kind;
    logic [AW-1:0]        addr;
    logic [GW-1:0]        gain;
    logic signed [SW-1:0] i;
    logic signed [SW-1:0] q;
  } op_t;

  localparam logic [CNT_W:0] DEPTH_LIM = (CNT_W + 1)'(RAMP_DEPTH);

  phase_e                phase_q, phase_d;
  logic [CNT_W-1:0]      countdown_q, countdown_d;
  logic                  run_q, run_d;
  logic                  flag_q, flag_d;
  logic                  active_q, active_d;
  logic [DELAY_W-1:0]    delay_q, delay_d;
  logic [RAMP_LEN_W-1:0] ramp_q, ramp_d;
  op_t                   op;
  logic                  push;
  logic                  accept;
  logic                  nonzero;
  logic [CNT_W-1:0]      ramp_idx;
  logic [CNT_W-1:0]      load_idx;
  logic                  ramp_in_range;
  logic                  load_in_range;

  assign in_ready_o    = push_ready_i;
  assign accept        = in_valid_i & push_ready_i;
  assign nonzero       = (i_in_i != '0) || (q_in_i != '0);
  assign ramp_idx      = CNT_W'(ramp_q) - countdown_q;
  assign load_idx      = CNT_W'(ramp_index_i);
  assign ramp_in_range = {1'b0, ramp_idx} < DEPTH_LIM;
  assign load_in_range = {1'b0, load_idx} < DEPTH_LIM;

  always_comb begin
    phase_d     = phase_q;
    countdown_d = countdown_q;
    run_d       = run_q;
    flag_d      = flag_q;
    active_d    = active_q;
    delay_d     = delay_q;
    ramp_d      = ramp_q;
    push        = 1'b0;
    op.kind     = OP_PASS;
    op.addr     = '0;
    op.gain     = ramp_gain_i;
    op.i        = i_in_i;
    op.q        = q_in_i;

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_DELAY: delay_d = cfg_data_i;
        REG_RAMP:  ramp_d  = cfg_data_i[RAMP_LEN_W-1:0];
      endcase
      run_d       = 1'b0;
      flag_d      = 1'b0;
      phase_d     = PH_BEGIN;
      countdown_d = '0;
    end else if (accept) begin
      unique case (cmd_e'(command_i))
        CMD_FLUSH: begin
          phase_d = PH_BEGIN;
          run_d   = 1'b0;
          flag_d  = 1'b0;
        end
        CMD_SET_RUN: begin
          run_d = run_value_i;
        end
        CMD_LOAD: begin
          push    = load_in_range;
          op.kind = OP_LOAD;
          op.addr = load_idx[AW-1:0];
        end
        CMD_SAMPLE: begin
          push = 1'b1;
          // Block start: arm on a pending check, then decide gating.
          if (block_start_i) begin
            if (!run_q && check_i) begin
              run_d = 1'b1;
            end
            active_d = run_d & flag_q;
            flag_d   = 1'b1;
          end
          if (active_d) begin
            unique case (phase_q)
              PH_BEGIN: begin
                op.kind = OP_ZERO;
                if (nonzero) begin
                  if (delay_q != '0) begin
                    phase_d     = PH_WAIT;
                    countdown_d = delay_q;
                  end else if (ramp_q != '0) begin
                    phase_d     = PH_UP;
                    countdown_d = CNT_W'(ramp_q);
                  end else begin
                    phase_d = PH_ON;
                  end
                end
              end
              PH_WAIT: begin
                op.kind = OP_ZERO;
                if (countdown_q == '0) begin
                  if (ramp_q != '0) begin
                    phase_d     = PH_UP;
                    countdown_d = CNT_W'(ramp_q);
                  end else begin
                    phase_d = PH_ON;
                  end
                end else begin
                  countdown_d = countdown_q - 1'b1;
                end
              end
              PH_UP: begin
                op.kind = ramp_in_range ? OP_RAMP : OP_ZERO;
                op.addr = ramp_idx[AW-1:0];
                if (countdown_q == '0) begin
                  phase_d = PH_ON;
                end else begin
                  countdown_d = countdown_q - 1'b1;
                end
              end
              PH_ON: begin
                flag_d = 1'b0;
                run_d  = 1'b0;
              end
              default: begin
                phase_d = PH_BEGIN;
              end
            endcase
          end
        end
      endcase
    end
  end

  assign push_valid_o = push;
  assign push_op_o    = op;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_BEGIN;
      countdown_q <= '0;
      run_q       <= 1'b0;
      flag_q      <= 1'b0;
      active_q    <= 1'b0;
      delay_q     <= '0;
      ramp_q      <= '0;
    end else begin
      phase_q     <= phase_d;
      countdown_q <= countdown_d;
      run_q       <= run_d;
      flag_q      <= flag_d;
      active_q    <= active_d;
      delay_q     <= delay_d;
      ramp_q      <= ramp_d;
    end
  end

  a_up_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_UP) |-> (countdown_q <= CNT_W'(ramp_q)))
    else $error("ramp countdown beyond ramp length");

  a_flush_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && command_i == CMD_FLUSH) |=> (phase_q == PH_BEGIN && !run_q && !flag_q))
    else $error("flush did not restart the gate");

endmodule

@@ src/rcug_queue.sv @@
// Small FIFO that decouples the front end from the sample datapath.
module rcug_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push;
  logic             do_pop;

  assign push_ready_o = count_q != CNT_W'(DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign pop_data_o   = entry_q[rd_ptr_q];
  assign do_push      = push_valid_i & push_ready_o;
  assign do_pop       = pop_ready_i & pop_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("queue fill count beyond depth");

endmodule

@@ src/rcug_back.sv @@
// Back end: ramp table, gain multiply, rounding and saturation, output register.
module rcug_back #(
  parameter int SW         = 16,
  parameter int GW         = 17,
  parameter int AW         = 10,
  parameter int RAMP_DEPTH = 1024,
  localparam int OP_W      = rcug_pkg::OP_KIND_W + AW + GW + 2 * SW
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 pop_valid_i,
  output logic                 pop_ready_o,
  input  logic [OP_W-1:0]      pop_op_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic signed [SW-1:0] i_out_o,
  output logic signed [SW-1:0] q_out_o
);
  import rcug_pkg::*;

  typedef struct packed {
    op_kind_e             kind;
    logic [AW-1:0]        addr;
    logic [GW-1:0]        gain;
    logic signed [SW-1:0] i;
    logic signed [SW-1:0] q;
  } op_t;

  localparam int FB = GW - 1;
  localparam int PW = SW + GW + 1;
  localparam int RW = PW - FB;
  localparam logic signed [PW-1:0] HALF = PW'(64'sd1 <<< (FB - 1));
  localparam logic signed [RW-1:0] HI   = RW'((64'sd1 <<< (SW - 1)) - 64'sd1);
  localparam logic signed [RW-1:0] LO   = RW'(-(64'sd1 <<< (SW - 1)));

  function automatic logic signed [SW-1:0] round_sat(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] biased;
    logic signed [RW-1:0] r;
    biased = p + HALF;
    r      = biased[PW-1:FB];
    if (r > HI) begin
      return HI[SW-1:0];
    end else if (r < LO) begin
      return LO[SW-1:0];
    end
    return r[SW-1:0];
  endfunction

  op_t                  op;
  logic                 adv;
  logic [GW-1:0]        ramp_mem [RAMP_DEPTH];

  logic                 v1_q;
  op_kind_e             kind1_q;
  logic signed [SW-1:0] i1_q, q1_q;
  logic [GW-1:0]        g1_q;

  logic                 v2_q;
  op_kind_e             kind2_q;
  logic signed [SW-1:0] i2_q, q2_q;
  logic signed [PW-1:0] pi_q, pq_q;
  logic signed [PW-1:0] pi_d, pq_d;
  logic signed [GW:0]   gain_s;

  logic                 out_valid_q;
  logic signed [SW-1:0] i_out_q, i_out_d;
  logic signed [SW-1:0] q_out_q, q_out_d;

  assign op          = pop_op_i;
  // Advance the whole pipe whenever the output register is free.
  assign adv         = !out_valid_q || out_ready_i;
  assign pop_ready_o = adv;

  // Table port: one address per cycle; a load writes and also reads, read data registered.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (pop_valid_i && op.kind == OP_LOAD) begin
        ramp_mem[op.addr] <= op.gain;
      end
      g1_q <= ramp_mem[op.addr];
    end
  end

  assign gain_s = $signed({1'b0, g1_q});

  always_comb begin
    pi_d = i1_q * gain_s;
    pq_d = q1_q * gain_s;
  end

  always_comb begin
    unique case (kind2_q)
      OP_PASS: begin
        i_out_d = i2_q;
        q_out_d = q2_q;
      end
      OP_RAMP: begin
        i_out_d = round_sat(pi_q);
        q_out_d = round_sat(pq_q);
      end
      OP_ZERO, OP_LOAD: begin
        i_out_d = '0;
        q_out_d = '0;
      end
      default: begin
        i_out_d = '0;
        q_out_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v1_q        <= pop_valid_i && (op.kind != OP_LOAD);
      v2_q        <= v1_q;
      out_valid_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      kind1_q <= op.kind;
      i1_q    <= op.i;
      q1_q    <= op.q;
      kind2_q <= kind1_q;
      i2_q    <= i1_q;
      q2_q    <= q1_q;
      pi_q    <= pi_d;
      pq_q    <= pq_d;
      if (v2_q) begin
        i_out_q <= i_out_d;
        q_out_q <= q_out_d;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign i_out_o     = i_out_q;
  assign q_out_o     = q_out_q;

  a_load_no_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && pop_valid_i && op.kind == OP_LOAD) |=> !v1_q)
    else $error("table load produced an output word");

  a_pipe_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && v2_q) |=> out_valid_o)
    else $error("datapath word lost before output register");

endmodule

@@ src/raised_cosine_upslew_gate_core.sv @@
// Top level of the raised-cosine upslew gate: front end, op queue and datapath.
//
// Usage:
//   Input words arrive on in_valid_i/in_ready_o with a command. Sample words
//   (command 0) each give one output word on out_valid_o/out_ready_i; flush,
//   set-run and table-load words give none. Load the ramp table (command 3)
//   before any ramp runs; entries never written read as garbage.
//   Configuration: cfg_we_i writes delay_samples (index 0) or ramp_samples
//   (index 1); any write also restarts the gate. Write only while the
//   block is idle.
//   Path: an accepted sample passes the queue, the table read, the multiply
//   and round/saturate into the output register. Throughput: one word per
//   cycle while the receiver does not stall, set by the single table port
//   and one multiplier per lane (I and Q each have their own).
//   Reset clears the gate state machine and the configuration to zero; the
//   table has no reset and no clearing pass, so the block is ready at once.
//   When the receiver stalls, the datapath freezes and the 4-entry op queue
//   absorbs words until it is full, then in_ready_o drops.
module raised_cosine_upslew_gate_core #(
  parameter int RAMP_DEPTH     = 1024,
  parameter int SAMPLE_WIDTH   = 16,
  parameter int GAIN_FRAC_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rcug_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rcug_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [rcug_pkg::CMD_W-1:0]      command_i,
  input  logic                            block_start_i,
  input  logic                            check_i,
  input  logic                            run_value_i,
  input  logic signed [SAMPLE_WIDTH-1:0]  i_in_i,
  input  logic signed [SAMPLE_WIDTH-1:0]  q_in_i,
  input  logic [rcug_pkg::RAMP_IDX_W-1:0] ramp_index_i,
  input  logic [GAIN_FRAC_BITS:0]         ramp_gain_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0]  i_out_o,
  output logic signed [SAMPLE_WIDTH-1:0]  q_out_o
);
  import rcug_pkg::*;

  localparam int AW   = (RAMP_DEPTH > 1) ? $clog2(RAMP_DEPTH) : 1;
  localparam int GW   = GAIN_FRAC_BITS + 1;
  localparam int OP_W = OP_KIND_W + AW + GW + 2 * SAMPLE_WIDTH;

  logic            push_valid;
  logic            push_ready;
  logic [OP_W-1:0] push_op;
  logic            pop_valid;
  logic            pop_ready;
  logic [OP_W-1:0] pop_op;

  // Classify each word and advance the gate state at acceptance.
  rcug_front #(
    .SW         (SAMPLE_WIDTH),
    .GW         (GW),
    .AW         (AW),
    .RAMP_DEPTH (RAMP_DEPTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .command_i     (command_i),
    .block_start_i (block_start_i),
    .check_i       (check_i),
    .run_value_i   (run_value_i),
    .i_in_i        (i_in_i),
    .q_in_i        (q_in_i),
    .ramp_index_i  (ramp_index_i),
    .ramp_gain_i   (ramp_gain_i),
    .push_valid_o  (push_valid),
    .push_ready_i  (push_ready),
    .push_op_o     (push_op)
  );

  // Hold ops in order so table loads and ramp reads never pass each other.
  rcug_queue #(
    .WIDTH (OP_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_op),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_op)
  );

  // Carry out each op: table access, scale, round, saturate, deliver.
  rcug_back #(
    .SW         (SAMPLE_WIDTH),
    .GW         (GW),
    .AW         (AW),
    .RAMP_DEPTH (RAMP_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_op_i    (pop_op),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .i_out_o     (i_out_o),
    .q_out_o     (q_out_o)
  );

endmodule

@@ bench/upslew_gate_checker.sv @@
`timescale 1ns / 100ps
// Channel monitor, gate predictor and output comparison for the upslew gate bench.
module upslew_gate_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rcug_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rcug_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  logic [rcug_pkg::CMD_W-1:0]      command_i,
  input  logic                            block_start_i,
  input  logic                            check_i,
  input  logic                            run_value_i,
  input  logic signed [15:0]              i_in_i,
  input  logic signed [15:0]              q_in_i,
  input  logic [rcug_pkg::RAMP_IDX_W-1:0] ramp_index_i,
  input  logic [16:0]                     ramp_gain_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  logic signed [15:0]              i_out_i,
  input  logic signed [15:0]              q_out_i,
  output int unsigned                     pending_o,
  output int unsigned                     fail_count_o
);
  import rcug_pkg::*;

  localparam int RAMP_DEPTH   = 1024;
  localparam int FRAC_BITS    = 16;
  localparam int REPORT_LIMIT = 10;

  typedef logic signed [15:0] sample_t;

  typedef struct packed {
    sample_t i_val;
    sample_t q_val;
  } gated_iq_t;

  // predictor state
  phase_e                gate_phase;
  logic [CNT_W-1:0]      countdown;
  logic                  run_armed;
  logic                  upslew_set;
  logic                  block_live;
  logic [DELAY_W-1:0]    hold_len;
  logic [RAMP_LEN_W-1:0] ramp_len;
  logic [16:0]           ramp_gains [RAMP_DEPTH];

  gated_iq_t   gated_due [$];
  gated_iq_t   head;
  sample_t     out_i;
  sample_t     out_q;
  logic [15:0] tap;
  logic [16:0] gain;
  int unsigned fail_total = 0;

  assign fail_count_o = fail_total;

  // Round to nearest with ties up, then clamp to the sample range.
  function automatic sample_t apply_gain(input sample_t s, input logic [16:0] g);
    logic signed [39:0] acc;
    acc = s * $signed({1'b0, g});
    acc = (acc + (40'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    if (acc > 40'sd32767) return 16'sh7FFF;
    if (acc < -40'sd32768) return 16'sh8000;
    return acc[15:0];
  endfunction

  function automatic void leave_zero_hold();
    if (ramp_len != 0) begin
      gate_phase = PH_UP;
      countdown  = {6'd0, ramp_len};
    end else begin
      gate_phase = PH_ON;
    end
  endfunction

  function automatic void restart_gate();
    run_armed  = 1'b0;
    upslew_set = 1'b0;
    gate_phase = PH_BEGIN;
    countdown  = '0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restart_gate();
      block_live = 1'b0;
      hold_len   = '0;
      ramp_len   = '0;
      gated_due.delete();
    end else begin
      // retire the oldest expectation first: a word leaving now entered earlier
      if (out_valid_i && out_ready_i) begin
        if (gated_due.size() == 0) begin
          fail_total++;
          if (fail_total <= REPORT_LIMIT)
            $display("%0t: output word with none expected: i=%0d q=%0d",
                     $realtime, i_out_i, q_out_i);
        end else begin
          head = gated_due.pop_front();
          if (i_out_i !== head.i_val || q_out_i !== head.q_val) begin
            fail_total++;
            if (fail_total <= REPORT_LIMIT)
              $display("%0t: mismatch: i expected %0d got %0d, q expected %0d got %0d",
                       $realtime, head.i_val, i_out_i, head.q_val, q_out_i);
          end
        end
      end

      if (cfg_we_i) begin
        if (cfg_idx_i == REG_DELAY) hold_len = cfg_data_i;
        else ramp_len = cfg_data_i[RAMP_LEN_W-1:0];
        restart_gate();
      end

      if (in_valid_i && in_ready_i) begin
        case (command_i)
          CMD_FLUSH: begin
            // block_live and countdown survive a flush
            gate_phase = PH_BEGIN;
            run_armed  = 1'b0;
            upslew_set = 1'b0;
          end
          CMD_SET_RUN: run_armed = run_value_i;
          CMD_LOAD:    ramp_gains[ramp_index_i] = ramp_gain_i;
          default: begin
            out_i = i_in_i;
            out_q = q_in_i;
            if (block_start_i) begin
              if (check_i) run_armed = 1'b1;
              block_live = run_armed & upslew_set;
              upslew_set = 1'b1;
            end
            if (block_live) begin
              case (gate_phase)
                PH_BEGIN: begin
                  out_i = '0;
                  out_q = '0;
                  if (i_in_i != 0 || q_in_i != 0) begin
                    if (hold_len != 0) begin
                      gate_phase = PH_WAIT;
                      countdown  = hold_len;
                    end else begin
                      leave_zero_hold();
                    end
                  end
                end
                PH_WAIT: begin
                  out_i = '0;
                  out_q = '0;
                  if (countdown == 0) leave_zero_hold();
                  else countdown = countdown - 1'b1;
                end
                PH_UP: begin
                  tap  = {6'd0, ramp_len} - countdown;
                  gain = (tap < RAMP_DEPTH) ? ramp_gains[tap[9:0]] : '0;
                  out_i = apply_gain(i_in_i, gain);
                  out_q = apply_gain(q_in_i, gain);
                  if (countdown == 0) gate_phase = PH_ON;
                  else countdown = countdown - 1'b1;
                end
                default: begin
                  upslew_set = 1'b0;
                  run_armed  = 1'b0;
                end
              endcase
            end
            gated_due.push_back('{i_val: out_i, q_val: out_q});
          end
        endcase
      end
    end
    pending_o <= gated_due.size();
  end

endmodule

@@ bench/tb_raised_cosine_upslew_gate_core.sv @@
`timescale 1ns / 100ps
// Bench top for the raised-cosine upslew gate: stimulus, flow control and verdict.
module tb_raised_cosine_upslew_gate_core;
  import rcug_pkg::*;

  localparam int     HALF_PERIOD    = 5;
  localparam int     RESET_CYCLES   = 11;
  // pipeline is queue plus three stages; leave plenty of slack for words
  // that produce no output but may still be in flight
  localparam int     DRAIN_CYCLES   = 16;
  localparam int     HOLD_CYCLES    = 64;
  localparam int     NUM_PHASES     = 9;
  localparam int     PHASE_WORDS    = 85;
  localparam int     PRESSURE_PHASE = 4;
  localparam longint TIMEOUT_NS     = 2_000_000;

  typedef struct packed {
    cmd_e               command;
    logic               block_start;
    logic               check;
    logic               run_value;
    logic signed [15:0] i_in;
    logic signed [15:0] q_in;
    logic [9:0]         ramp_index;
    logic [16:0]        ramp_gain;
  } tx_word_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                  in_valid_i    = 1'b0;
  logic                  in_ready_o;
  logic [CMD_W-1:0]      command_i     = '0;
  logic                  block_start_i = 1'b0;
  logic                  check_i       = 1'b0;
  logic                  run_value_i   = 1'b0;
  logic signed [15:0]    i_in_i        = '0;
  logic signed [15:0]    q_in_i        = '0;
  logic [RAMP_IDX_W-1:0] ramp_index_i  = '0;
  logic [16:0]           ramp_gain_i   = '0;
  logic                  out_valid_o;
  logic                  out_ready_i   = 1'b0;
  logic signed [15:0]    i_out_o;
  logic signed [15:0]    q_out_o;

  int unsigned pending;
  int unsigned fail_count;

  // flow-control knobs, in percent per cycle
  int   gap_pct     = 0;
  int   stall_pct   = 0;
  logic pressure_on = 1'b0;
  int   hold_left   = 0;
  logic hold_fired  = 1'b0;

  raised_cosine_upslew_gate_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .command_i     (command_i),
    .block_start_i (block_start_i),
    .check_i       (check_i),
    .run_value_i   (run_value_i),
    .i_in_i        (i_in_i),
    .q_in_i        (q_in_i),
    .ramp_index_i  (ramp_index_i),
    .ramp_gain_i   (ramp_gain_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .i_out_o       (i_out_o),
    .q_out_o       (q_out_o)
  );

  upslew_gate_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .command_i     (command_i),
    .block_start_i (block_start_i),
    .check_i       (check_i),
    .run_value_i   (run_value_i),
    .i_in_i        (i_in_i),
    .q_in_i        (q_in_i),
    .ramp_index_i  (ramp_index_i),
    .ramp_gain_i   (ramp_gain_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .i_out_i       (i_out_o),
    .q_out_i       (q_out_o),
    .pending_o     (pending),
    .fail_count_o  (fail_count)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // Receiver: stall at random per cycle, and hold off entirely while the
  // pressure counter runs.
  always @(posedge clk_i) begin
    out_ready_i <= (hold_left == 0) && ($urandom_range(0, 99) >= stall_pct);
  end

  // Long receiver hold-off, fired once when the pressure phase opens. The
  // sender keeps offering words meanwhile, so the op queue fills and the
  // block must drop in_ready_o.
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (pressure_on && !hold_fired) begin
      hold_left  <= HOLD_CYCLES;
      hold_fired <= 1'b1;
    end
  end

  // Fill every field with noise; callers overwrite what the command uses.
  function automatic tx_word_t junk_word();
    tx_word_t w;
    w.command     = cmd_e'(2'($urandom_range(0, 3)));
    w.block_start = 1'($urandom_range(0, 1));
    w.check       = 1'($urandom_range(0, 1));
    w.run_value   = 1'($urandom_range(0, 1));
    w.i_in        = 16'($urandom);
    w.q_in        = 16'($urandom);
    w.ramp_index  = 10'($urandom);
    w.ramp_gain   = 17'($urandom);
    return w;
  endfunction

  function automatic tx_word_t sample_word(input logic bs, input logic chk,
                                           input logic signed [15:0] i,
                                           input logic signed [15:0] q);
    tx_word_t w;
    w             = junk_word();
    w.command     = CMD_SAMPLE;
    w.block_start = bs;
    w.check       = chk;
    w.i_in        = i;
    w.q_in        = q;
    return w;
  endfunction

  function automatic tx_word_t ctrl_word(input cmd_e c, input logic run);
    tx_word_t w;
    w           = junk_word();
    w.command   = c;
    w.run_value = run;
    return w;
  endfunction

  function automatic tx_word_t load_word(input logic [9:0] a, input logic [16:0] g);
    tx_word_t w;
    w            = junk_word();
    w.command    = CMD_LOAD;
    w.ramp_index = a;
    w.ramp_gain  = g;
    return w;
  endfunction

  // Mostly gains within 0..1.0; the rest span the full 17-bit field so the
  // saturating path sees plenty of traffic.
  function automatic logic [16:0] rand_gain();
    if ($urandom_range(0, 9) < 7) return 17'($urandom_range(0, 65536));
    return 17'($urandom);
  endfunction

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(0, 9))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return 16'shFFFF;
      3:       return 16'sh0001;
      default: return 16'($urandom);
    endcase
  endfunction

  // Offer one word: idle first if the phase asks for gaps, then hold valid
  // and payload until the handshake completes.
  task automatic drive_word(input tx_word_t w);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    command_i     <= w.command;
    block_start_i <= w.block_start;
    check_i       <= w.check;
    run_value_i   <= w.run_value;
    i_in_i        <= w.i_in;
    q_in_i        <= w.q_in;
    ramp_index_i  <= w.ramp_index;
    ramp_gain_i   <= w.ramp_gain;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Drop valid, wait for every predicted output, then let words that make no
  // output clear the pipeline.
  task automatic drain_gate();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Write both registers back to back; only call with the block idle.
  task automatic reconfigure_gate(input logic [15:0] dly, input logic [9:0] rmp);
    drain_gate();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_DELAY;
    cfg_data_i <= dly;
    @(posedge clk_i);
    cfg_idx_i  <= REG_RAMP;
    cfg_data_i <= {6'd0, rmp};
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  initial begin
    tx_word_t           w;
    logic [15:0]        dly;
    logic [9:0]         rmp;
    int                 mode;
    int                 loaded_upto;
    int                 need;
    int                 blk_left;
    int                 lead_left;
    int                 span;
    int                 roll;
    logic               blk_check;
    logic               bs;
    logic signed [15:0] si;
    logic signed [15:0] sq;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: delay of one, four-tap ramp. Walk one active block through
    // every gate phase, then a flush inside an active block.
    reconfigure_gate(16'd1, 10'd3);
    drive_word(load_word(10'd0, 17'd0));
    drive_word(load_word(10'd1, 17'h1FFFF));       // gain well above one
    drive_word(load_word(10'd2, 17'd32768));       // half: exposes rounding ties
    drive_word(load_word(10'd3, 17'd65536));       // exactly one
    drive_word(load_word(10'd1023, rand_gain()));  // top address
    // first block only sets the upslew flag, samples pass through
    drive_word(sample_word(1'b1, 1'b0, 16'sh7FFF, 16'sh8000));
    // block_start on a non-sample command must be ignored
    w = ctrl_word(CMD_SET_RUN, 1'b1);
    w.block_start = 1'b1;
    drive_word(w);
    // active block: zeros held until the first nonzero sample and through the delay
    drive_word(sample_word(1'b1, 1'b0, 16'sh0000, 16'sh0000));
    drive_word(sample_word(1'b0, 1'b0, 16'sh8000, 16'sh7FFF));
    drive_word(sample_word(1'b0, 1'b0, 16'sh1234, 16'sh4321));
    drive_word(sample_word(1'b0, 1'b0, 16'sh7FFF, 16'sh8000));
    // ramp taps: zero gain, saturating gain, ties, unity
    drive_word(sample_word(1'b0, 1'b0, 16'sh7FFF, 16'sh8000));
    drive_word(sample_word(1'b0, 1'b0, 16'sh8000, 16'sh7FFF));
    drive_word(sample_word(1'b0, 1'b0, 16'shFFFF, 16'sh0001));
    drive_word(sample_word(1'b0, 1'b0, 16'sh7FFF, 16'sh8000));
    // pass-through phase clears the flag and persists
    drive_word(sample_word(1'b0, 1'b1, 16'sh0ABC, 16'shF543));
    drive_word(sample_word(1'b0, 1'b0, 16'sh8000, 16'shFFFF));
    drive_word(ctrl_word(CMD_FLUSH, 1'b0));
    // check arms run mode; flag is clear so the first block stays inactive, the second goes active
    drive_word(sample_word(1'b1, 1'b1, 16'sh0005, 16'sh0000));
    drive_word(sample_word(1'b1, 1'b1, 16'sh0005, 16'sh0000));
    // flush while active: zeros again, through the next nonzero sample and the delay
    drive_word(ctrl_word(CMD_FLUSH, 1'b1));
    drive_word(sample_word(1'b0, 1'b0, 16'sh0007, 16'sh0000));
    drive_word(sample_word(1'b0, 1'b0, 16'sh0000, 16'sh0000));
    drive_word(ctrl_word(CMD_SET_RUN, 1'b0));
    loaded_upto = 4;

    // Random phases: mostly well-formed blocks that reach the ramp, with
    // stray block starts, flushes, run writes and table loads mixed in.
    blk_left  = 0;
    lead_left = 0;
    blk_check = 1'b0;
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       begin dly = 16'd0;     rmp = 10'd0;    end
        1:       begin dly = 16'hFFFF;  rmp = 10'd1023; end
        2:       begin dly = 16'd0;     rmp = 10'd1023; end
        default: begin
          dly = 16'($urandom_range(0, 4));
          rmp = 10'($urandom_range(1, 12));
        end
      endcase
      reconfigure_gate(dly, rmp);

      mode      = p % 4;
      gap_pct   = (mode == 1) ? 73 : (mode == 3) ? 13 : 0;
      stall_pct <= (mode == 2) ? 73 : (mode == 3) ? 13 : 0;
      pressure_on <= (p == PRESSURE_PHASE);

      // A ramp can read no deeper than the samples in this phase; make sure
      // every tap it could reach has been loaded.
      need = (rmp < PHASE_WORDS) ? rmp : PHASE_WORDS;
      while (loaded_upto <= need) begin
        drive_word(load_word(10'(loaded_upto), rand_gain()));
        loaded_upto++;
      end

      span     = ((dly < 20) ? dly : 20) + ((rmp < 20) ? rmp : 20) + 12;
      blk_left = 0;
      for (int n = 0; n < PHASE_WORDS; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 6) begin
          w = load_word(10'($urandom), rand_gain());
        end else if (roll < 9) begin
          w = ctrl_word(CMD_FLUSH, 1'($urandom));
        end else if (roll < 13) begin
          w = ctrl_word(CMD_SET_RUN, 1'($urandom));
        end else begin
          bs = 1'b0;
          if (blk_left == 0) begin
            blk_left  = $urandom_range(1, span);
            lead_left = $urandom_range(0, 3);
            blk_check = ($urandom_range(0, 99) < 85);
            bs        = 1'b1;
          end else if ($urandom_range(0, 99) < 3) begin
            bs = 1'b1;  // stray block start mid-block
          end
          if (lead_left > 0) begin
            si = '0;
            sq = '0;
            lead_left--;
          end else begin
            si = rand_sample();
            sq = rand_sample();
          end
          w = sample_word(bs, bs ? blk_check : 1'($urandom), si, sq);
          blk_left--;
        end
        drive_word(w);
      end
    end

    drain_gate();
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("timeout with %0d output words outstanding", pending);
    $display("== FAIL ==");
    $finish;
  end

endmodule

@@ sim.f @@
src/rcug_pkg.sv
src/rcug_front.sv
src/rcug_queue.sv
src/rcug_back.sv
src/raised_cosine_upslew_gate_core.sv
bench/upslew_gate_checker.sv
bench/tb_raised_cosine_upslew_gate_core.sv
